### sv/acpt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// acpt_pkg
// Shared types and constants for the ABC constant-pool tokenizer.
// ============================================================================
package acpt_pkg;

    // Parse phases; the values of the token-producing phases double as
    // token kinds.
    typedef enum logic [3:0] {
        PH_MINOR     = 4'd0,
        PH_MAJOR     = 4'd1,
        PH_INTCOUNT  = 4'd2,
        PH_INT       = 4'd3,
        PH_UINTCOUNT = 4'd4,
        PH_UINT      = 4'd5,
        PH_DBLCOUNT  = 4'd6,
        PH_DBL       = 4'd7,
        PH_STRCOUNT  = 4'd8,
        PH_STRLEN    = 4'd9,
        PH_STRBYTE   = 4'd10,
        PH_NSCOUNT   = 4'd11,
        PH_NSKIND    = 4'd12,
        PH_NSNAME    = 4'd13,
        PH_DONE      = 4'd14
    } t_phase;

    // Varint decoding constants
    localparam logic [6:0] VINT_LOW_MASK = 7'h7F;
    localparam logic [3:0] U30_TOP_MASK  = 4'h3;
    localparam logic [3:0] U32_TOP_MASK  = 4'hF;
    localparam int         VINT_SHIFT    = 7;
    localparam int         TOP_SHIFT     = 28;

    // Depth of the queue between front and back
    localparam int ACPT_FIFO_DEPTH = 4;

    // Input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_start;
    } t_in_item;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_start;
        logic       more;        // varint continuation bit
    } t_cls_item;

    // Output token
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic [29:0] entry_number;
        logic        pool_complete;
    } t_out_item;

endpackage

### sv/abc_constant_pool_tokenizer.sv
`timescale 1ns / 1ps
// ============================================================================
// abc_constant_pool_tokenizer
// Byte-serial tokenizer for the constant pool of an ABC body.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / i_in_item / o_in_stall) carries one body
//   byte per request; body_start set on a byte restarts parsing with that
//   byte as the first minor-version byte.
//   Output channel (o_out_valid / o_out_item / i_out_stall) carries one
//   token per finished field or string byte; bytes that only extend a field
//   give no token.
//   Throughput: one byte per cycle while the output is not stalled, set by
//   the parser step in the back stage; the queue absorbs short output stalls.
//   Each byte passes through the input register, the queue and the output
//   register on its way to its token.
//   When i_out_stall holds a token the parser waits; bytes collect in the
//   queue and the input register, and once both are full o_in_stall rises.
//   Reset (synchronous, active low) empties the pipeline and returns the
//   parser to the minor version.
// ============================================================================
module abc_constant_pool_tokenizer import acpt_pkg::*; #(
    parameter int FIFO_DEPTH = ACPT_FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic      w_push;
    logic      w_full;
    logic      w_pop;
    logic      w_empty;
    t_cls_item w_cls_in;
    t_cls_item w_cls_out;

    acpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_push  (w_push),
        .o_cls   (w_cls_in),
        .i_full  (w_full)
    );

    acpt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_cls_out)
    );

    acpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cls   (w_cls_out),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

### sv/acpt_front.sv
`timescale 1ns / 1ps
// ============================================================================
// acpt_front
// Input stage: registers each request and tags the varint continuation bit.
// ============================================================================
module acpt_front import acpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_push,
    output t_cls_item o_cls,
    input  logic      i_full
);

    logic      r_valid;
    t_cls_item r_cls;
    logic      w_load;

    // Hold input only while the stage is occupied and the queue is full
    assign o_stall = r_valid && i_full;
    assign w_load  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register: classify on the way in
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cls.data_byte  <= i_item.data_byte;
            r_cls.body_start <= i_item.body_start;
            r_cls.more       <= i_item.data_byte[7];
        end
    end

endmodule

### sv/acpt_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// acpt_fifo
// Short queue of classified bytes between the front and back stages.
// ============================================================================
module acpt_fifo import acpt_pkg::*; #(
    parameter int DEPTH = ACPT_FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_cls_item o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls_item         r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/acpt_back.sv
`timescale 1ns / 1ps
// ============================================================================
// acpt_back
// Parser: walks the constant-pool grammar one byte a cycle unless stalled
// or starved, and drives the output token register.
// ============================================================================
module acpt_back import acpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cls_item i_cls,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    // Parser state
    t_phase      r_phase,  n_phase;
    logic [63:0] r_acc,    n_acc;
    logic [3:0]  r_pos,    n_pos;
    logic [29:0] r_left,   n_left;
    logic [29:0] r_cnt,    n_cnt;
    logic [29:0] r_sleft,  n_sleft;

    // Output register
    logic        r_valid;
    t_out_item   r_item;

    // State as seen after an optional restart
    t_phase      w_ph;
    logic [63:0] w_acc;
    logic [3:0]  w_pos;
    logic [29:0] w_left;
    logic [29:0] w_cnt;
    logic [29:0] w_sleft;

    logic        w_emit;
    t_out_item   w_tok;
    logic [63:0] w_vacc;
    logic        w_vfin;
    logic [3:0]  w_top_mask;
    logic [29:0] w_count;
    logic [29:0] w_dec;
    logic [29:0] w_sdec;

    // Merge one varint byte into the accumulator
    function automatic logic [63:0] vint_acc(input logic [63:0] acc,
                                             input logic [3:0]  pos,
                                             input logic [7:0]  b,
                                             input logic [3:0]  top_mask);
        logic [63:0] lo;
        logic [63:0] hi;
        begin
            lo = {57'd0, b[6:0] & VINT_LOW_MASK};
            hi = {60'd0, b[3:0] & top_mask};
            if (pos < 4'd4) begin
                vint_acc = acc | (lo << (VINT_SHIFT * pos[1:0]));
            end else begin
                vint_acc = acc | (hi << TOP_SHIFT);
            end
        end
    endfunction

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Restart view
    always_comb begin
        if (i_cls.body_start) begin
            w_ph    = PH_MINOR;
            w_acc   = '0;
            w_pos   = '0;
            w_left  = '0;
            w_cnt   = '0;
            w_sleft = '0;
        end else begin
            w_ph    = r_phase;
            w_acc   = r_acc;
            w_pos   = r_pos;
            w_left  = r_left;
            w_cnt   = r_cnt;
            w_sleft = r_sleft;
        end
    end

    // Varint helpers shared by all varint phases
    always_comb begin
        w_top_mask = (w_ph == PH_INT || w_ph == PH_UINT) ? U32_TOP_MASK : U30_TOP_MASK;
        w_vacc     = vint_acc(w_acc, w_pos, i_cls.data_byte, w_top_mask);
        w_vfin     = !i_cls.more || (w_pos >= 4'd4);
        w_count    = w_vacc[29:0];
        w_dec      = w_left - 30'd1;
        w_sdec     = w_sleft - 30'd1;
    end

    // Grammar next state and token
    always_comb begin
        n_phase = w_ph;
        n_acc   = w_acc;
        n_pos   = w_pos;
        n_left  = w_left;
        n_cnt   = w_cnt;
        n_sleft = w_sleft;
        w_emit  = 1'b0;
        w_tok.token_kind    = w_ph;
        w_tok.token_value   = w_vacc;
        w_tok.entry_number  = w_cnt;
        w_tok.pool_complete = 1'b0;

        unique case (w_ph)
            // Two-byte little-endian versions
            PH_MINOR, PH_MAJOR: begin
                if (!w_pos[0]) begin
                    n_acc = w_acc | {56'd0, i_cls.data_byte};
                    n_pos = 4'd1;
                end else begin
                    w_emit = 1'b1;
                    w_tok.token_value  = w_acc | {48'd0, i_cls.data_byte, 8'd0};
                    w_tok.entry_number = '0;
                    n_acc   = '0;
                    n_pos   = '0;
                    n_phase = (w_ph == PH_MINOR) ? PH_MAJOR : PH_INTCOUNT;
                end
            end

            // Section counts
            PH_INTCOUNT, PH_UINTCOUNT, PH_DBLCOUNT, PH_STRCOUNT, PH_NSCOUNT: begin
                if (!w_vfin) begin
                    n_acc = w_vacc;
                    n_pos = w_pos + 4'd1;
                end else begin
                    w_emit = 1'b1;
                    w_tok.entry_number = '0;
                    n_acc  = '0;
                    n_pos  = '0;
                    n_left = (w_count == '0) ? '0 : w_count - 30'd1;
                    if (n_left != '0) begin
                        n_cnt = 30'd1;
                        unique case (w_ph)
                            PH_INTCOUNT:  n_phase = PH_INT;
                            PH_UINTCOUNT: n_phase = PH_UINT;
                            PH_DBLCOUNT:  n_phase = PH_DBL;
                            PH_STRCOUNT:  n_phase = PH_STRLEN;
                            default:      n_phase = PH_NSKIND;
                        endcase
                    end else begin
                        n_cnt = '0;
                        unique case (w_ph)
                            PH_INTCOUNT:  n_phase = PH_UINTCOUNT;
                            PH_UINTCOUNT: n_phase = PH_DBLCOUNT;
                            PH_DBLCOUNT:  n_phase = PH_STRCOUNT;
                            PH_STRCOUNT:  n_phase = PH_NSCOUNT;
                            default:      n_phase = PH_DONE;
                        endcase
                        w_tok.pool_complete = (w_ph == PH_NSCOUNT);
                    end
                end
            end

            // Integer entries, truncated to 32 bits
            PH_INT, PH_UINT: begin
                if (!w_vfin) begin
                    n_acc = w_vacc;
                    n_pos = w_pos + 4'd1;
                end else begin
                    w_emit = 1'b1;
                    w_tok.token_value = {32'd0, w_vacc[31:0]};
                    n_acc  = '0;
                    n_pos  = '0;
                    n_left = w_dec;
                    if (w_dec != '0) begin
                        n_cnt = w_cnt + 30'd1;
                    end else begin
                        n_cnt   = '0;
                        n_phase = (w_ph == PH_INT) ? PH_UINTCOUNT : PH_DBLCOUNT;
                    end
                end
            end

            // Raw 8-byte doubles
            PH_DBL: begin
                if (w_pos[2:0] != 3'd7) begin
                    n_acc = w_acc | ({56'd0, i_cls.data_byte} << (8 * w_pos[2:0]));
                    n_pos = {1'b0, w_pos[2:0] + 3'd1};
                end else begin
                    w_emit = 1'b1;
                    w_tok.token_value = w_acc | {i_cls.data_byte, 56'd0};
                    n_acc  = '0;
                    n_pos  = '0;
                    n_left = w_dec;
                    if (w_dec != '0) begin
                        n_cnt = w_cnt + 30'd1;
                    end else begin
                        n_cnt   = '0;
                        n_phase = PH_STRCOUNT;
                    end
                end
            end

            // String length
            PH_STRLEN: begin
                if (!w_vfin) begin
                    n_acc = w_vacc;
                    n_pos = w_pos + 4'd1;
                end else begin
                    w_emit  = 1'b1;
                    n_acc   = '0;
                    n_pos   = '0;
                    n_sleft = w_count;
                    if (w_count != '0) begin
                        n_phase = PH_STRBYTE;
                    end else begin
                        n_left = w_dec;
                        if (w_dec != '0) begin
                            n_cnt = w_cnt + 30'd1;
                        end else begin
                            n_cnt   = '0;
                            n_phase = PH_NSCOUNT;
                        end
                    end
                end
            end

            // String body bytes
            PH_STRBYTE: begin
                w_emit  = 1'b1;
                w_tok.token_value = {56'd0, i_cls.data_byte};
                n_sleft = w_sdec;
                if (w_sdec == '0) begin
                    n_left = w_dec;
                    if (w_dec != '0) begin
                        n_cnt   = w_cnt + 30'd1;
                        n_phase = PH_STRLEN;
                    end else begin
                        n_cnt   = '0;
                        n_phase = PH_NSCOUNT;
                    end
                end
            end

            // Namespace kind byte
            PH_NSKIND: begin
                w_emit  = 1'b1;
                w_tok.token_value = {56'd0, i_cls.data_byte};
                n_phase = PH_NSNAME;
            end

            // Namespace name index
            PH_NSNAME: begin
                if (!w_vfin) begin
                    n_acc = w_vacc;
                    n_pos = w_pos + 4'd1;
                end else begin
                    w_emit = 1'b1;
                    n_acc  = '0;
                    n_pos  = '0;
                    n_left = w_dec;
                    if (w_dec != '0) begin
                        n_cnt   = w_cnt + 30'd1;
                        n_phase = PH_NSKIND;
                    end else begin
                        n_cnt   = '0;
                        n_phase = PH_DONE;
                        w_tok.pool_complete = 1'b1;
                    end
                end
            end

            // Trailing bytes after the pool are dropped
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MINOR;
            r_acc   <= '0;
            r_pos   <= '0;
            r_left  <= '0;
            r_cnt   <= '0;
            r_sleft <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
            r_sleft <= n_sleft;
        end
    end

    // Output token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_item <= w_tok;
        end
    end

endmodule

### sv/acpt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// acpt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ============================================================================
module acpt_checker import acpt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // A stalled token stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("token dropped while stalled");

    // A stalled token keeps its payload
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("token changed while stalled");

    // Pool end is flagged only by the namespace count or name
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pool_complete) |->
        (o_out_item.token_kind == PH_NSCOUNT || o_out_item.token_kind == PH_NSNAME))
        else $error("pool end on wrong token");

    // Versions and counts carry no entry number
    a_count_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.token_kind == PH_MINOR ||
                         o_out_item.token_kind == PH_MAJOR ||
                         o_out_item.token_kind == PH_INTCOUNT ||
                         o_out_item.token_kind == PH_UINTCOUNT ||
                         o_out_item.token_kind == PH_DBLCOUNT ||
                         o_out_item.token_kind == PH_STRCOUNT ||
                         o_out_item.token_kind == PH_NSCOUNT)) |->
        (o_out_item.entry_number == '0))
        else $error("count token with entry number");

    // Int, string-byte and namespace-kind tokens carry a nonzero entry number
    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.token_kind == PH_INT ||
                         o_out_item.token_kind == PH_STRBYTE ||
                         o_out_item.token_kind == PH_NSKIND)) |->
        (o_out_item.entry_number != '0))
        else $error("entry token without entry number");

endmodule

bind abc_constant_pool_tokenizer acpt_checker u_acpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
